// File: hw/rtl/fir_lp_pkg.sv
package fir_lp_pkg;

  localparam int TAPS       = 20;
  localparam int PAIRS      = TAPS / 2;
  localparam int GRP        = PAIRS / 2;
  localparam int SAMPLE_W   = 10;
  localparam int PAIR_BITS  = SAMPLE_W + 1;
  localparam int CNT_W      = $clog2(PAIR_BITS + 1);
  localparam int OUT_W      = 26;
  localparam int DA_W       = 16;
  localparam int DA_ENTRIES = 1 << GRP;
  localparam int ACC_HI_W   = 17;
  localparam int SUM_W      = ACC_HI_W + PAIR_BITS;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic [PAIRS-1:0][DA_W-1:0] coef_half_t;
  typedef logic [DA_ENTRIES-1:0][DA_W-1:0] da_tbl_t;

  // First half of each symmetric coefficient set; element 0 is the newest tap.
  localparam coef_half_t COEF_WIDE_HALF = {
    16'sd6688, 16'sd5183, 16'sd3052, 16'sd1286, 16'sd311,
    -16'sd27, -16'sd65, -16'sd33, -16'sd10, -16'sd2
  };

  localparam coef_half_t COEF_NARROW_HALF = {
    16'sd127, 16'sd111, 16'sd83, 16'sd51, 16'sd24,
    16'sd7, -16'sd2, -16'sd4, -16'sd3, -16'sd2
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } fir_lp_state_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic coef_set;
  } fir_lp_ctl_t;

  // Each entry is the sum of the coefficients of a group of tap pairs whose
  // address bits are set.
  function automatic da_tbl_t build_tbl(input logic narrow, input int base);
    da_tbl_t t;
    logic signed [DA_W-1:0] acc;
    for (int a = 0; a < DA_ENTRIES; a++) begin
      acc = '0;
      for (int i = 0; i < GRP; i++) begin
        if (((a >> i) & 1) != 0) begin
          if (narrow) begin
            acc = acc + $signed(COEF_NARROW_HALF[base + i]);
          end else begin
            acc = acc + $signed(COEF_WIDE_HALF[base + i]);
          end
        end
      end
      t[a] = acc;
    end
    return t;
  endfunction

  localparam da_tbl_t DA_WIDE_LO   = build_tbl(1'b0, 0);
  localparam da_tbl_t DA_WIDE_HI   = build_tbl(1'b0, GRP);
  localparam da_tbl_t DA_NARROW_LO = build_tbl(1'b1, 0);
  localparam da_tbl_t DA_NARROW_HI = build_tbl(1'b1, GRP);

endpackage

// File: hw/rtl/fir_lp_da_acc.sv
module fir_lp_da_acc (
  input  logic                                clk,
  input  fir_lp_pkg::fir_lp_ctl_t             ctl,
  input  logic [fir_lp_pkg::GRP-1:0]          addr_lo,
  input  logic [fir_lp_pkg::GRP-1:0]          addr_hi,
  output logic signed [fir_lp_pkg::SUM_W-1:0] sum
);

  logic signed [fir_lp_pkg::DA_W-1:0]       ent_lo;
  logic signed [fir_lp_pkg::DA_W-1:0]       ent_hi;
  logic signed [fir_lp_pkg::DA_W:0]         term;
  logic signed [fir_lp_pkg::ACC_HI_W:0]     part;
  logic signed [fir_lp_pkg::ACC_HI_W-1:0]   hi_r;
  logic signed [fir_lp_pkg::ACC_HI_W-1:0]   hi_nxt;
  logic [fir_lp_pkg::PAIR_BITS-1:0]         lo_r;
  logic [fir_lp_pkg::PAIR_BITS-1:0]         lo_nxt;

  always_comb begin
    if (ctl.coef_set) begin
      ent_lo = fir_lp_pkg::DA_NARROW_LO[addr_lo];
      ent_hi = fir_lp_pkg::DA_NARROW_HI[addr_hi];
    end else begin
      ent_lo = fir_lp_pkg::DA_WIDE_LO[addr_lo];
      ent_hi = fir_lp_pkg::DA_WIDE_HI[addr_hi];
    end
    term   = {ent_lo[fir_lp_pkg::DA_W-1], ent_lo} + {ent_hi[fir_lp_pkg::DA_W-1], ent_hi};
    part   = {hi_r[fir_lp_pkg::ACC_HI_W-1], hi_r}
           + {{(fir_lp_pkg::ACC_HI_W - fir_lp_pkg::DA_W){term[fir_lp_pkg::DA_W]}}, term};
    hi_nxt = part[fir_lp_pkg::ACC_HI_W:1];
    lo_nxt = {part[0], lo_r[fir_lp_pkg::PAIR_BITS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hi_r <= '0;
      lo_r <= '0;
    end else if (ctl.step) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign sum = {hi_r, lo_r};

endmodule

// File: hw/rtl/fir_lowpass_twenty_tap_unit.sv
// Twenty-tap symmetric low-pass FIR filter for an unsigned 10-bit sample stream.
// Input channel: in_valid, in_stall, in_sample. One item is one new sample.
// Output channel: out_valid, out_stall, out_filtered, the signed 26-bit tap sum,
// saturated to the 26-bit range. Each input item gives exactly one output item.
// Configuration: cfg_wr_en with cfg_wr_data selects the coefficient set (0 for
// the 16-bit set, 1 for the 8-bit set); write it only while the filter is idle.
// The pair sums of the sample history are formed bit-serially, one bit per
// cycle, and each bit slice is weighted through two small coefficient tables.
// An item runs in order from acceptance to out_valid: the history shifts at
// the accepting edge, then the bit-serial pass runs over the 11-bit pair
// sums, and then the saturated sum is loaded into the output register. One
// item is in work at a time, and the filter returns to idle after the output
// load before it accepts the next item. While the output register is still
// held by out_stall, the finished sum waits and in_stall stays high.
// A synchronous reset clears the sample history, the coefficient selection and
// the output valid flag.
module fir_lowpass_twenty_tap_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fir_lp_pkg::SAMPLE_W-1:0]     in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fir_lp_pkg::OUT_W-1:0] out_filtered,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data
);

  fir_lp_pkg::fir_lp_state_t state_r;
  fir_lp_pkg::fir_lp_state_t state_nxt;

  logic [fir_lp_pkg::SAMPLE_W-1:0]     hist_r [fir_lp_pkg::TAPS];
  logic [fir_lp_pkg::CNT_W-1:0]        cnt_r;
  logic [fir_lp_pkg::CNT_W-1:0]        cnt_nxt;
  logic [fir_lp_pkg::PAIRS-1:0]        carry_r;
  logic [fir_lp_pkg::PAIRS-1:0]        carry_nxt;
  logic [fir_lp_pkg::PAIRS-1:0]        pair_bit;
  logic                                coef_set_r;
  logic                                out_valid_r;
  logic signed [fir_lp_pkg::OUT_W-1:0] out_filtered_r;
  logic signed [fir_lp_pkg::OUT_W-1:0] sat_val;
  logic signed [fir_lp_pkg::SUM_W-1:0] sum;
  logic                                accept;
  logic                                rot_en;
  logic                                run_last;
  logic                                load_out;
  logic                                out_free;
  fir_lp_pkg::fir_lp_ctl_t             ctl;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign run_last = (cnt_r == fir_lp_pkg::CNT_W'(fir_lp_pkg::PAIR_BITS - 1));
  assign rot_en   = (state_r == fir_lp_pkg::ST_RUN)
                 && (cnt_r < fir_lp_pkg::CNT_W'(fir_lp_pkg::SAMPLE_W));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fir_lp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = fir_lp_pkg::ST_RUN;
        end
      end
      fir_lp_pkg::ST_RUN: begin
        if (run_last) begin
          state_nxt = fir_lp_pkg::ST_DRAIN;
        end
      end
      fir_lp_pkg::ST_DRAIN: begin
        if (out_free) begin
          state_nxt = fir_lp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fir_lp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    ctl.clear    = 1'b0;
    ctl.step     = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      fir_lp_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        ctl.clear = in_valid;
      end
      fir_lp_pkg::ST_RUN: begin
        ctl.step = 1'b1;
      end
      fir_lp_pkg::ST_DRAIN: begin
        load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    ctl.coef_set = coef_set_r;
  end

  always_comb begin
    for (int j = 0; j < fir_lp_pkg::PAIRS; j++) begin
      logic a;
      logic b;
      a = rot_en && hist_r[j][0];
      b = rot_en && hist_r[fir_lp_pkg::TAPS-1-j][0];
      pair_bit[j]  = a ^ b ^ carry_r[j];
      carry_nxt[j] = (a & b) | (carry_r[j] & (a ^ b));
    end
    cnt_nxt = cnt_r + fir_lp_pkg::CNT_W'(1);
  end

  always_comb begin
    if (!sum[fir_lp_pkg::SUM_W-1]
        && (sum[fir_lp_pkg::SUM_W-2:fir_lp_pkg::OUT_W-1] != '0)) begin
      sat_val = fir_lp_pkg::OUT_MAX;
    end else if (sum[fir_lp_pkg::SUM_W-1]
                 && (sum[fir_lp_pkg::SUM_W-2:fir_lp_pkg::OUT_W-1] != '1)) begin
      sat_val = fir_lp_pkg::OUT_MIN;
    end else begin
      sat_val = sum[fir_lp_pkg::OUT_W-1:0];
    end
  end

  fir_lp_da_acc u_da_acc (
    .clk     (clk),
    .ctl     (ctl),
    .addr_lo (pair_bit[fir_lp_pkg::GRP-1:0]),
    .addr_hi (pair_bit[fir_lp_pkg::PAIRS-1:fir_lp_pkg::GRP]),
    .sum     (sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fir_lp_pkg::ST_IDLE;
      coef_set_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      carry_r     <= '0;
      for (int k = 0; k < fir_lp_pkg::TAPS; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        coef_set_r <= cfg_wr_data;
      end
      if (accept) begin
        cnt_r     <= '0;
        carry_r   <= '0;
        hist_r[0] <= in_sample;
        for (int k = 1; k < fir_lp_pkg::TAPS; k++) begin
          hist_r[k] <= hist_r[k-1];
        end
      end else if (ctl.step) begin
        cnt_r   <= cnt_nxt;
        carry_r <= carry_nxt;
        if (rot_en) begin
          for (int k = 0; k < fir_lp_pkg::TAPS; k++) begin
            hist_r[k] <= {hist_r[k][0], hist_r[k][fir_lp_pkg::SAMPLE_W-1:1]};
          end
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_filtered_r <= sat_val;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

`ifndef SYNTHESIS
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == fir_lp_pkg::ST_RUN) && (cnt_r == '0))
    else $error("accepted item did not start the bit-serial pass");

  a_run_ends_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fir_lp_pkg::ST_RUN) && run_last |=> state_r == fir_lp_pkg::ST_DRAIN)
    else $error("bit-serial pass did not end after the last pair-sum bit");

  a_carries_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fir_lp_pkg::ST_RUN) && run_last |=> carry_r == '0)
    else $error("pair-sum carries not flushed at the end of the pass");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(out_filtered_r))
    else $error("held output item was overwritten");
`endif

endmodule
